>>> rtl/core/pfs_pkg.sv
// Shared types and constants for the prime filtered stack.
`timescale 1ns / 1ps

package pfs_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_DONE,
    ST_RESP
  } pfs_state_e;

  typedef logic [1:0] pfs_status_t;

  localparam pfs_status_t StOk        = 2'd0;
  localparam pfs_status_t StReject    = 2'd1;
  localparam pfs_status_t StFull      = 2'd2;
  localparam pfs_status_t StUnderflow = 2'd3;

  localparam int unsigned ValueW   = 32;
  // magnitude bits of a positive candidate
  localparam int unsigned MagW     = ValueW - 1;
  localparam int unsigned DivW     = 16;
  localparam int unsigned StepW    = $clog2(MagW);
  localparam int unsigned SqW      = 32;

  localparam int unsigned Divisor  = 3;
  localparam int unsigned Additive = 1;
  // (n + Additive) % Divisor == 0  <=>  n % Divisor == Divisor - Additive
  localparam logic [DivW-1:0] Mod3Target  = DivW'(Divisor - Additive);
  localparam logic [DivW-1:0] FirstDiv    = DivW'(Divisor);
  localparam logic [DivW-1:0] SecondDiv   = DivW'(Divisor + 2);
  localparam logic [SqW-1:0]  FirstDivSq  = SqW'(Divisor * Divisor);
  localparam logic [SqW-1:0]  SecondDivSq = SqW'((Divisor + 2) * (Divisor + 2));

endpackage

>>> rtl/core/prime_filtered_stack_unit.sv
// Prime filtered LIFO stack: push filter by trial division, fixed-depth store.
//
// Input channel (in_valid_i / in_stall_o) takes one request: mode_i = 0 pushes
// value_i, mode_i = 1 pops the top entry. A push is kept only when value_i is
// prime and value_i + 1 is a multiple of three; otherwise status 1. A passing
// push to a full stack is dropped with status 2; a pop from an empty stack
// returns zero with status 3. stack_empty_o reports the state after the request.
// Each request yields exactly one result on out_valid_o / out_stall_i.
// One request is in work at a time; in_stall_o is high from acceptance until
// the result is moved into the output register.
// A pop, or a push settled without division (value below two, two, even), goes
// straight to the done state. An odd push runs a bit-serial remainder unit, one
// divisor at a time with a check step after each: first modulo three, then odd
// divisors from five while divisor squared <= value.
// The output register lets a new request be accepted while a result waits;
// a stalled result holds, and the next result waits behind it.
// Reset clears the entry count, the sequencer and the output valid; the store
// itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module prime_filtered_stack_unit
  import pfs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic signed [31:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]        status_o,
  output logic              stack_empty_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  pfs_state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // request and divider registers (no reset)
  logic              mode_q, mode_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [MagW-1:0]   n_q, n_d;
  logic [MagW-1:0]   nsh_q, nsh_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]   div_q, div_d;
  logic [SqW-1:0]    dsq_q, dsq_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              mod3_q, mod3_d;
  logic              pass_q, pass_d;
  logic              pop_ok_q, pop_ok_d;
  pfs_status_t       status_q, status_d;

  logic signed [ValueW-1:0] out_value_q;
  pfs_status_t       out_status_q;
  logic              out_empty_q;

  logic [ValueW-1:0] mem [STACK_DEPTH];
  logic [ValueW-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  wr_addr, rd_addr;

  logic              in_accept, out_free, out_load;
  logic [DivW:0]     rem_shift, rem_sub;
  logic              rem_ge;
  logic [DivW-1:0]   rem_final;
  logic              div_last, is_full;
  logic [CntW-1:0]   count_dec;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == ST_RESP) && out_free;
  assign is_full   = (count_q == CntW'(STACK_DEPTH));
  assign count_dec = count_q - CntW'(1);

  // shared remainder step: restoring, one dividend bit per cycle
  assign rem_shift = {rem_q, nsh_q[MagW-1]};
  assign rem_sub   = rem_shift - {1'b0, div_q};
  assign rem_ge    = (rem_shift >= {1'b0, div_q});
  assign rem_final = rem_ge ? rem_sub[DivW-1:0] : rem_shift[DivW-1:0];
  assign div_last  = (step_q == StepW'(MagW - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_i || value_i <= 32'sd2 || !value_i[0]) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_last) begin
          if (mod3_q) begin
            state_d = (rem_final != Mod3Target) ? ST_DONE : ST_CHECK;
          end else begin
            state_d = (rem_final == '0) ? ST_DONE : ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_d = (dsq_q > {1'b0, n_q}) ? ST_DONE : ST_DIV;
      end
      ST_DONE: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    mode_d   = mode_q;
    value_d  = value_q;
    n_d      = n_q;
    nsh_d    = nsh_q;
    rem_d    = rem_q;
    div_d    = div_q;
    dsq_d    = dsq_q;
    step_d   = step_q;
    mod3_d   = mod3_q;
    pass_d   = pass_q;
    pop_ok_d = pop_ok_q;
    status_d = status_q;
    count_d  = count_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    wr_addr  = count_q[AddrW-1:0];
    rd_addr  = count_dec[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d  = mode_i;
          value_d = value_i;
          n_d     = value_i[MagW-1:0];
          nsh_d   = value_i[MagW-1:0];
          rem_d   = '0;
          step_d  = '0;
          div_d   = FirstDiv;
          dsq_d   = FirstDivSq;
          mod3_d  = 1'b1;
          // two passes outright; below two and other evens fail
          pass_d  = (value_i == 32'sd2);
        end
      end
      ST_DIV: begin
        nsh_d  = {nsh_q[MagW-2:0], 1'b0};
        rem_d  = rem_final;
        step_d = step_q + StepW'(1);
        if (div_last) begin
          if (mod3_q) begin
            pass_d = 1'b0;
            mod3_d = 1'b0;
            div_d  = SecondDiv;
            dsq_d  = SecondDivSq;
          end else begin
            pass_d = 1'b0;
            div_d  = div_q + DivW'(2);
            // (d + 2)^2 = d^2 + 4d + 4
            dsq_d  = dsq_q + {{(SqW - DivW - 2){1'b0}}, div_q, 2'b00} + SqW'(4);
          end
        end
      end
      ST_CHECK: begin
        if (dsq_q > {1'b0, n_q}) begin
          pass_d = 1'b1;
        end else begin
          nsh_d  = n_q;
          rem_d  = '0;
          step_d = '0;
        end
      end
      ST_DONE: begin
        pop_ok_d = 1'b0;
        if (!mode_q) begin
          if (!pass_q) begin
            status_d = StReject;
          end else if (is_full) begin
            status_d = StFull;
          end else begin
            status_d = StOk;
            mem_we   = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end else begin
          if (count_q == '0) begin
            status_d = StUnderflow;
          end else begin
            status_d = StOk;
            pop_ok_d = 1'b1;
            mem_re   = 1'b1;
            count_d  = count_dec;
          end
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    value_q  <= value_d;
    n_q      <= n_d;
    nsh_q    <= nsh_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    dsq_q    <= dsq_d;
    step_q   <= step_d;
    mod3_q   <= mod3_d;
    pass_q   <= pass_d;
    pop_ok_q <= pop_ok_d;
    status_q <= status_d;
    if (out_load) begin
      out_value_q  <= pop_ok_q ? rd_q : '0;
      out_status_q <= status_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  // stack store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign stack_empty_o  = out_empty_q;

endmodule

>>> rtl/core/pfs_checker.sv
// Port-level checks for the prime filtered stack, bound to the top level.
`timescale 1ns / 1ps

module pfs_checker
  import pfs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [31:0] popped_value_o,
  input logic [1:0]        status_o,
  input logic              stack_empty_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(popped_value_o)
      && $stable(status_o) && $stable(stack_empty_o))
    else $error("stalled result changed");

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // underflow leaves the stack empty and returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StUnderflow |-> popped_value_o == '0 && stack_empty_o)
    else $error("bad underflow result");

  // pushes never return data; a full stack is not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StReject || status_o == StFull) |-> popped_value_o == '0)
    else $error("push returned data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFull |-> !stack_empty_o)
    else $error("full drop reported empty stack");

endmodule

bind prime_filtered_stack_unit pfs_checker u_pfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .popped_value_o (popped_value_o),
  .status_o       (status_o),
  .stack_empty_o  (stack_empty_o)
);

>>> test/prime_filtered_stack_unit_test.sv
// Testbench for the prime filtered stack unit: directed, fill, backpressure and random tests.
`timescale 1ns / 1ps

module prime_filtered_stack_unit_test;
  import pfs_pkg::*;

  localparam int unsigned StackDepth = 1024;
  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;

  typedef struct {
    logic signed [31:0] popped;
    pfs_status_t        status;
    logic               empty;
  } stack_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              mode_i;
  logic signed [31:0] value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [31:0] popped_value_o;
  logic [1:0]        status_o;
  logic              stack_empty_o;

  logic signed [31:0] stack_model[$];
  stack_result_t      pending_results[$];
  int unsigned        mismatches = 0;
  int unsigned        hold_request;
  bit                 tx_idle_on;
  bit                 rx_idle_on;

  prime_filtered_stack_unit #(
    .STACK_DEPTH(StackDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .stack_empty_o (stack_empty_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // prime and (n + 1) divisible by three
  function automatic bit keeps_value(logic signed [31:0] v);
    longint n;
    longint d;
    n = longint'(v);
    if (n <= 1) return 1'b0;
    if ((n + 1) % 3 != 0) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic stack_result_t apply_request(logic m, logic signed [31:0] v);
    stack_result_t r;
    r.popped = '0;
    if (m == ModePush) begin
      if (!keeps_value(v)) begin
        r.status = StReject;
      end else if (stack_model.size() >= StackDepth) begin
        r.status = StFull;
      end else begin
        stack_model.push_back(v);
        r.status = StOk;
      end
    end else begin
      if (stack_model.size() == 0) begin
        r.status = StUnderflow;
      end else begin
        r.popped = stack_model.pop_back();
        r.status = StOk;
      end
    end
    r.empty = (stack_model.size() == 0);
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_request(input logic m, input logic signed [31:0] v);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(m, v));
    @(negedge clk_i);
  endtask

  task automatic check_result();
    stack_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: popped %0d status %0d empty %0b",
                 popped_value_o, status_o, stack_empty_o);
    end else begin
      want = pending_results.pop_front();
      if (popped_value_o !== want.popped || status_o !== want.status ||
          stack_empty_o !== want.empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected popped %0d status %0d empty %0b, got %0d %0d %0b",
                   want.popped, want.status, want.empty,
                   popped_value_o, status_o, stack_empty_o);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
  end

  // receiver: random stalls, or one long hold when it is requested
  initial begin
    int unsigned stall_len;
    bit          hold_done;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      stall_len = 0;
      if (hold_request > 0 && !hold_done) begin
        stall_len = hold_request;
        hold_done = 1'b1;
      end else if (rx_idle_on) begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_directed_edges();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    offer_request(ModePop, 32'sh0);           // underflow right after reset
    offer_request(ModePush, 32'sh8000_0000);  // most negative
    offer_request(ModePush, -32'sd1);
    offer_request(ModePush, 32'sd0);
    offer_request(ModePush, 32'sd1);
    offer_request(ModePush, 32'sd2);          // only even value kept
    offer_request(ModePush, 32'sd3);          // prime, 4 not a multiple of three
    offer_request(ModePush, 32'sd4);
    offer_request(ModePush, 32'sd5);
    offer_request(ModePush, 32'sd25);
    offer_request(ModePush, 32'sd35);         // composite, passes the mod-3 test
    offer_request(ModePush, 32'sd2147483647); // prime but 2^31 not a multiple of three
    offer_request(ModePush, 32'sd2147483646);
    offer_request(ModePush, 32'sd2147483645);
    offer_request(ModePush, 32'sd99989);
    offer_request(ModePush, 32'sd11);
    offer_request(ModePop, -32'sd1);          // value ignored on pop
    offer_request(ModePop, 32'sh5555_5555);
    offer_request(ModePop, 32'sh0);
    offer_request(ModePop, 32'sh0);
    offer_request(ModePop, 32'sh0);
    offer_request(ModePop, 32'sh0);
  endtask

  task automatic test_fill_and_drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (stack_model.size() < StackDepth) begin
      if ($urandom_range(0, 3) == 0) offer_request(ModePush, $urandom_range(3, 200));
      else offer_request(ModePush, 32'sd2);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    offer_request(ModePush, 32'sd2);   // dropped, full
    offer_request(ModePush, 32'sd17);  // dropped, full
    offer_request(ModePush, 32'sd9);   // filter wins over fullness
    offer_request(ModePush, -32'sd7);
    offer_request(ModePop, $urandom());
    offer_request(ModePush, 32'sd5);   // fits again
    offer_request(ModePush, 32'sd5);   // full again
    tx_idle_on = 1'b0;
    while (stack_model.size() > 0) offer_request(ModePop, $urandom());
    offer_request(ModePop, $urandom());
  endtask

  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 6; i++) offer_request(ModePush, (i % 2) ? 32'sd11 : 32'sd2);
    for (int i = 0; i < 8; i++) offer_request(ModePop, $urandom());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int unsigned roll;
    int unsigned pop_weight;
    logic signed [31:0] v;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 700; i++) begin
      // alternate push-heavy and pop-heavy stretches so the stack grows and drains
      pop_weight = ((i / 50) % 2 == 0) ? 20 : 55;
      if (i >= 300 && i < 400) rx_idle_on = 1'b0;
      else rx_idle_on = 1'b1;
      if ($urandom_range(0, 99) < pop_weight) begin
        offer_request(ModePop, $urandom());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          v = 6 * $urandom_range(0, 166) + 5;
        end else if (roll < 70) begin
          v = $urandom_range(0, 1000);
        end else begin
          v = $urandom();
          // keep large odd candidates off the long division path: force a factor of 5
          if (v > 1000 && v[0] && v % 3 == 2) v = v - v % 15 - 10;
        end
        offer_request(ModePush, v);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = ModePush;
    value_i      = '0;
    hold_request = 0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
